@@ hdl/gic_pkg.sv @@
// shared types, codes and constants of the grouped interrupt controller
package gic_pkg;

  localparam int unsigned LINES_PER_GROUP = 16;
  localparam int unsigned LINE_W          = 48;
  localparam int unsigned GROUPS_DEF      = 3;
  localparam int unsigned GROUP_W         = 2;
  localparam int unsigned FIRST_W         = 6;
  localparam int unsigned IRQ_W           = 3;
  localparam int unsigned CFG_DATA_W      = 64;
  localparam int unsigned CFG_ADDR_W      = 4;

  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_READ   = 2'd1;
  localparam logic [1:0] MODE_WRITE  = 2'd2;

  localparam logic REG_PENDING = 1'b0;
  localparam logic REG_MASK    = 1'b1;

  // register index, taken from address bit 3 (registers sit on 8 byte steps)
  localparam logic CFG_IDX_EDGE     = 1'b0;
  localparam logic CFG_IDX_POLARITY = 1'b1;

  typedef logic [LINES_PER_GROUP-1:0] word_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic               reg_sel;
    logic [GROUP_W-1:0] group;
    word_t              write_data;
    logic [LINE_W-1:0]  sources;
  } in_item_t;

  typedef struct packed {
    logic [IRQ_W-1:0]   group_irq;
    logic               irq_any;
    logic [FIRST_W-1:0] first_pending;
    logic               first_valid;
  } status_t;

  typedef struct packed {
    word_t              read_data;
    logic [IRQ_W-1:0]   group_irq;
    logic               irq_any;
    logic [FIRST_W-1:0] first_pending;
    logic               first_valid;
  } out_item_t;

endpackage

@@ hdl/gic_state.sv @@
// pending, mask and previous-line state with its per-item update
module gic_state #(
  parameter int unsigned GROUPS = gic_pkg::GROUPS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 fire,
  input  gic_pkg::in_item_t                    item,
  input  logic [gic_pkg::LINE_W-1:0]           edge_select,
  input  logic [gic_pkg::LINE_W-1:0]           polarity,
  output logic [GROUPS-1:0][gic_pkg::LINES_PER_GROUP-1:0] pend_nxt,
  output logic [GROUPS-1:0][gic_pkg::LINES_PER_GROUP-1:0] mask_nxt,
  output gic_pkg::word_t                       read_data
);

  localparam int unsigned LPG = gic_pkg::LINES_PER_GROUP;

  logic [GROUPS-1:0][LPG-1:0] pend_r;
  logic [GROUPS-1:0][LPG-1:0] mask_r;
  logic [gic_pkg::LINE_W-1:0] prev_r;
  logic [gic_pkg::LINE_W-1:0] adj;
  logic [GROUPS-1:0][LPG-1:0] hit;

  assign adj = item.sources ^ polarity;

  // lines beyond the source word never latch
  for (genvar g = 0; g < GROUPS; g++) begin : g_lane
    if ((g + 1) * LPG <= gic_pkg::LINE_W) begin : g_live
      logic [LPG-1:0] a, p, e;
      assign a = adj[g*LPG +: LPG];
      assign p = prev_r[g*LPG +: LPG];
      assign e = edge_select[g*LPG +: LPG];
      assign hit[g] = (e & a & ~p) | (~e & a);
    end else begin : g_dead
      assign hit[g] = '0;
    end
  end

  always_comb begin
    pend_nxt  = pend_r;
    mask_nxt  = mask_r;
    read_data = '0;
    for (int g = 0; g < GROUPS; g++) begin
      if (item.group == gic_pkg::GROUP_W'(g)) begin
        case (item.mode)
          gic_pkg::MODE_READ: begin
            read_data = (item.reg_sel == gic_pkg::REG_MASK) ? mask_r[g] : pend_r[g];
          end
          gic_pkg::MODE_WRITE: begin
            if (item.reg_sel == gic_pkg::REG_MASK) begin
              mask_nxt[g] = item.write_data;
            end else begin
              pend_nxt[g] = pend_r[g] & ~item.write_data;
            end
          end
          default: ;
        endcase
      end
      if (item.mode == gic_pkg::MODE_SAMPLE) begin
        pend_nxt[g] = pend_r[g] | hit[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      mask_r <= '1;
      prev_r <= '0;
    end else if (fire) begin
      pend_r <= pend_nxt;
      mask_r <= mask_nxt;
      if (item.mode == gic_pkg::MODE_SAMPLE) begin
        prev_r <= adj;
      end
    end
  end

endmodule

@@ hdl/gic_status.sv @@
// irq summary and lowest unmasked pending line
module gic_status #(
  parameter int unsigned GROUPS = gic_pkg::GROUPS_DEF
) (
  input  logic [GROUPS-1:0][gic_pkg::LINES_PER_GROUP-1:0] pend,
  input  logic [GROUPS-1:0][gic_pkg::LINES_PER_GROUP-1:0] mask,
  output gic_pkg::status_t                                status
);

  localparam int unsigned LPG   = gic_pkg::LINES_PER_GROUP;
  localparam int unsigned BIT_W = gic_pkg::FIRST_W - gic_pkg::GROUP_W;

  logic [GROUPS-1:0][LPG-1:0]   live;
  logic [GROUPS-1:0]            grp_hit;
  logic [GROUPS-1:0][BIT_W-1:0] grp_low;

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      live[g]    = pend[g] & ~mask[g];
      grp_hit[g] = |live[g];
      grp_low[g] = '0;
      for (int b = LPG - 1; b >= 0; b--) begin
        if (live[g][b]) begin
          grp_low[g] = BIT_W'(b);
        end
      end
    end
  end

  always_comb begin
    status = '0;
    status.irq_any = |grp_hit;
    for (int g = 0; g < GROUPS; g++) begin
      if (g < gic_pkg::IRQ_W) begin
        status.group_irq[g] = grp_hit[g];
      end
    end
    // scan down so the lowest group with a live line wins
    for (int g = GROUPS - 1; g >= 0; g--) begin
      if (grp_hit[g]) begin
        status.first_valid   = 1'b1;
        status.first_pending = {gic_pkg::GROUP_W'(g), grp_low[g]};
      end
    end
  end

endmodule

@@ hdl/grouped_interrupt_controller_unit.sv @@
// top level of the grouped interrupt controller: handshake stages and config port
// Grouped interrupt controller, GROUPS groups of sixteen lines. Each input item
// either samples the 48 source lines (mode sample), reads a group's pending or
// mask word (mode read) or writes a mask word / clears pending bits by writing
// ones (mode write); every item returns exactly one result item showing the
// read word (zero unless a read) and the irq status after the item's update.
// Source lines are xored with polarity and then latch into pending either on a
// rising edge (edge_select bit 1) or while active (edge_select bit 0). A mask bit
// of 0 enables its line. Throughput is one item per clock while the result channel
// is not stalled; the item sits in the input register, the state update and
// priority encode run combinationally, and the result register loads as the item
// leaves the input register.
// edge_select (byte address 0) and polarity (byte address 8) are written over
// the APB-style port and are meant to change only while no item is in flight.
module grouped_interrupt_controller_unit #(
  parameter int unsigned GROUPS = gic_pkg::GROUPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  gic_pkg::in_item_t                  in_item,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output gic_pkg::out_item_t                 out_item,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [gic_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [gic_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [gic_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready
);

  localparam int unsigned LPG = gic_pkg::LINES_PER_GROUP;

  // configuration registers
  logic [gic_pkg::LINE_W-1:0] edge_sel_r;
  logic [gic_pkg::LINE_W-1:0] polarity_r;
  logic                       cfg_wr;
  logic                       cfg_idx;

  // input stage
  logic              s1_vld_r;
  gic_pkg::in_item_t s1_item_r;
  logic              s1_adv;

  // result stage
  logic               out_vld_r;
  gic_pkg::out_item_t out_item_r;
  logic               s2_take;

  logic [GROUPS-1:0][LPG-1:0] pend_nxt;
  logic [GROUPS-1:0][LPG-1:0] mask_nxt;
  gic_pkg::word_t             rd_word;
  gic_pkg::status_t           status;

  // ---------------------------------------------------------------------------
  // config port: always ready, register chosen by address bit 3
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_idx = paddr[3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (cfg_idx)
      gic_pkg::CFG_IDX_EDGE:     prdata = gic_pkg::CFG_DATA_W'(edge_sel_r);
      gic_pkg::CFG_IDX_POLARITY: prdata = gic_pkg::CFG_DATA_W'(polarity_r);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_sel_r <= '1;
      polarity_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        gic_pkg::CFG_IDX_EDGE:     edge_sel_r <= pwdata[gic_pkg::LINE_W-1:0];
        gic_pkg::CFG_IDX_POLARITY: polarity_r <= pwdata[gic_pkg::LINE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // handshake: the result register frees when empty or taken, the input
  // register moves on whenever the result register can accept
  // ---------------------------------------------------------------------------
  assign s2_take  = !out_vld_r || out_ready;
  assign s1_adv   = s1_vld_r && s2_take;
  assign in_ready = !s1_vld_r || s2_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_item;
    end
  end

  // ---------------------------------------------------------------------------
  // state update for the item in the input register
  // ---------------------------------------------------------------------------
  gic_state #(
    .GROUPS (GROUPS)
  ) u_state (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (s1_adv),
    .item        (s1_item_r),
    .edge_select (edge_sel_r),
    .polarity    (polarity_r),
    .pend_nxt    (pend_nxt),
    .mask_nxt    (mask_nxt),
    .read_data   (rd_word)
  );

  // status reflects the state after this item's update
  gic_status #(
    .GROUPS (GROUPS)
  ) u_status (
    .pend   (pend_nxt),
    .mask   (mask_nxt),
    .status (status)
  );

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s2_take) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_item_r.read_data     <= rd_word;
      out_item_r.group_irq     <= status.group_irq;
      out_item_r.irq_any       <= status.irq_any;
      out_item_r.first_pending <= status.first_pending;
      out_item_r.first_valid   <= status.first_valid;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

endmodule

@@ test/grouped_interrupt_controller_unit_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench of the grouped interrupt controller: directed table, then random phases
module grouped_interrupt_controller_unit_tb;

  localparam int unsigned NGROUPS     = gic_pkg::GROUPS_DEF;
  localparam int unsigned LPG         = gic_pkg::LINES_PER_GROUP;
  // mode three is a no-op item; group three lies past the last group
  localparam logic [1:0]                     MODE_IDLE  = 2'd3;
  localparam logic [gic_pkg::GROUP_W-1:0]    GROUP_NONE = 2'd3;
  // registers sit on 8 byte steps, index in address bit 3
  localparam logic [gic_pkg::CFG_ADDR_W-1:0] ADDR_EDGE  = {gic_pkg::CFG_IDX_EDGE, 3'b000};
  localparam logic [gic_pkg::CFG_ADDR_W-1:0] ADDR_POL   = {gic_pkg::CFG_IDX_POLARITY, 3'b000};
  localparam logic [gic_pkg::LINE_W-1:0]     ALL_LINES  = '1;
  localparam logic                  TYPED      = 1'b1;
  localparam logic                  PREDICTED  = 1'b0;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_ITEMS = 72;
  localparam int unsigned QUIET_ITEMS = 50;
  localparam int unsigned LONG_HOLD   = 120;
  localparam int unsigned HOLD_AT     = 180;
  localparam int unsigned MAX_REPORTS = 10;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  gic_pkg::in_item_t              in_item;
  logic                           out_valid;
  logic                           out_ready;
  gic_pkg::out_item_t             out_item;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [gic_pkg::CFG_ADDR_W-1:0] paddr;
  logic [gic_pkg::CFG_DATA_W-1:0] pwdata;
  logic [gic_pkg::CFG_DATA_W-1:0] prdata;
  logic                           pready;

  grouped_interrupt_controller_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // controller state as the testbench sees it
  // ---------------------------------------------------------------------------
  gic_pkg::word_t             pend_st [NGROUPS];
  gic_pkg::word_t             mask_st [NGROUPS];
  logic [gic_pkg::LINE_W-1:0] last_lines;    // polarity-adjusted lines of the last sample
  logic [gic_pkg::LINE_W-1:0] edge_cfg;
  logic [gic_pkg::LINE_W-1:0] pol_cfg;

  // status items still owed by the block, oldest first
  gic_pkg::out_item_t         awaited[$];

  typedef struct packed {
    logic               typed;
    gic_pkg::in_item_t  item;
    gic_pkg::out_item_t want;
  } plan_row_t;

  plan_row_t         plan_q[$];

  int unsigned                n_sent;
  int unsigned                n_directed;
  int unsigned                n_results;
  int unsigned                n_errors;
  int unsigned                n_cfg_writes;
  logic                       quiet;         // last stretch: no idling on either side
  logic                       held_long;
  logic [gic_pkg::LINE_W-1:0] src_hist;      // sources of the last random sample
  gic_pkg::out_item_t         want_now;

  task automatic flag_error(input string msg);
    n_errors++;
    if (n_errors <= MAX_REPORTS)
      $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  function automatic void clear_irq_state();
    for (int g = 0; g < NGROUPS; g++) begin
      pend_st[g] = '0;
      mask_st[g] = '1;
    end
    last_lines = '0;
    edge_cfg   = ALL_LINES;
    pol_cfg    = '0;
  endfunction

  // applies one item to the state and returns the status that follows it
  function automatic gic_pkg::out_item_t next_irq_status(input gic_pkg::in_item_t it);
    gic_pkg::out_item_t         res;
    logic [gic_pkg::LINE_W-1:0] adj;
    gic_pkg::word_t             act;
    gic_pkg::word_t             prev;
    gic_pkg::word_t             edg;
    gic_pkg::word_t             live;
    int unsigned                line_no;
    res = '0;
    case (it.mode)
      gic_pkg::MODE_SAMPLE: begin
        adj = it.sources ^ pol_cfg;
        for (int g = 0; g < NGROUPS; g++) begin
          act  = adj[g*LPG +: LPG];
          prev = last_lines[g*LPG +: LPG];
          edg  = edge_cfg[g*LPG +: LPG];
          // edge lines need a low-to-high step, level lines latch while active
          pend_st[g] = pend_st[g] | (edg & act & ~prev) | (~edg & act);
        end
        last_lines = adj;
      end
      gic_pkg::MODE_READ: begin
        if (it.group < NGROUPS)
          res.read_data = (it.reg_sel == gic_pkg::REG_MASK) ? mask_st[it.group]
                                                            : pend_st[it.group];
      end
      gic_pkg::MODE_WRITE: begin
        if (it.group < NGROUPS) begin
          if (it.reg_sel == gic_pkg::REG_MASK)
            mask_st[it.group] = it.write_data;
          else
            pend_st[it.group] = pend_st[it.group] & ~it.write_data;
        end
      end
      default: ;
    endcase
    for (int g = 0; g < NGROUPS; g++) begin
      live = pend_st[g] & ~mask_st[g];
      if (live != '0) begin
        res.irq_any = 1'b1;
        if (g < gic_pkg::IRQ_W)
          res.group_irq[g] = 1'b1;
        for (int b = 0; b < LPG; b++) begin
          if (!res.first_valid && live[b]) begin
            line_no           = g * LPG + b;
            res.first_pending = line_no[gic_pkg::FIRST_W-1:0];
            res.first_valid   = 1'b1;
          end
        end
      end
    end
    return res;
  endfunction

  function automatic void add_row(input logic typed, input logic [1:0] md, input logic sel,
                                  input logic [gic_pkg::GROUP_W-1:0] grp,
                                  input gic_pkg::word_t wd,
                                  input logic [gic_pkg::LINE_W-1:0] src,
                                  input gic_pkg::out_item_t want);
    plan_row_t r;
    r.typed            = typed;
    r.item.mode        = md;
    r.item.reg_sel     = sel;
    r.item.group       = grp;
    r.item.write_data  = wd;
    r.item.sources     = src;
    r.want             = want;
    plan_q.push_back(r);
  endfunction

  // random item: samples most often, with sparse or toggling lines, plus bus traffic
  function automatic gic_pkg::in_item_t rand_item();
    gic_pkg::in_item_t it;
    int unsigned       pick;
    int unsigned       grp;
    logic [63:0]       r1;
    logic [63:0]       r2;
    logic [63:0]       r3;
    it   = '0;
    r1   = {$urandom, $urandom};
    r2   = {$urandom, $urandom};
    r3   = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 45)
      it.mode = gic_pkg::MODE_SAMPLE;
    else if (pick < 65)
      it.mode = gic_pkg::MODE_READ;
    else if (pick < 94)
      it.mode = gic_pkg::MODE_WRITE;
    else
      it.mode = MODE_IDLE;
    it.reg_sel = r3[8];
    grp        = $urandom_range(0, NGROUPS - 1);
    it.group   = ($urandom_range(0, 9) == 0) ? GROUP_NONE : grp[gic_pkg::GROUP_W-1:0];
    case ($urandom_range(0, 3))
      0:       it.write_data = r1[15:0];
      1:       it.write_data = r1[15:0] & r2[15:0];
      2:       it.write_data = r1[15:0] | r2[15:0];
      default: it.write_data = {LPG{r3[0]}};
    endcase
    case ($urandom_range(0, 4))
      0:       it.sources = r1[gic_pkg::LINE_W-1:0];
      1:       it.sources = r1[gic_pkg::LINE_W-1:0] & r2[gic_pkg::LINE_W-1:0]
                            & r3[gic_pkg::LINE_W-1:0];
      2:       it.sources = src_hist ^ (48'd1 << $urandom_range(0, gic_pkg::LINE_W - 1));
      3:       it.sources = src_hist;
      default: it.sources = {gic_pkg::LINE_W{r3[5]}};
    endcase
    if (it.mode == gic_pkg::MODE_SAMPLE)
      src_hist = it.sources;
    return it;
  endfunction

  // offers one item, records what it should produce, then maybe idles a while
  task automatic send_item(input gic_pkg::in_item_t it, input logic typed,
                           input gic_pkg::out_item_t want);
    gic_pkg::out_item_t pred;
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // the predictor runs even on typed rows so its state stays in step
    pred = next_irq_status(it);
    awaited.push_back(typed ? want : pred);
    n_sent++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // waits until the block owes nothing
  task automatic drain_results();
    while (awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write then read-back over the config port
  task automatic cfg_set(input logic [gic_pkg::CFG_ADDR_W-1:0] addr,
                         input logic [gic_pkg::LINE_W-1:0] value);
    logic [gic_pkg::CFG_DATA_W-1:0] full;
    full    = {{(gic_pkg::CFG_DATA_W - gic_pkg::LINE_W){1'b0}}, value};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= full;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_EDGE)
      edge_cfg = value;
    else
      pol_cfg = value;
    n_cfg_writes++;
    // straight into the setup phase of the read
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== full)
      flag_error($sformatf("register at %h: want %h, read back %h", addr, full, prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls, one long hold-off to back the block up
  // ---------------------------------------------------------------------------
  initial begin
    out_ready = 1'b0;
    held_long = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held_long && n_sent >= HOLD_AT) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        held_long = 1'b1;
      end else if (quiet || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
    end
  end

  // every accepted result is matched against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (awaited.size() == 0) begin
        flag_error($sformatf("result %h with nothing expected", out_item));
      end else begin
        want_now = awaited.pop_front();
        if (out_item.read_data     !== want_now.read_data     ||
            out_item.group_irq     !== want_now.group_irq     ||
            out_item.irq_any       !== want_now.irq_any       ||
            out_item.first_pending !== want_now.first_pending ||
            out_item.first_valid   !== want_now.first_valid)
          flag_error($sformatf(
            {"result %0d: want rd=%h irq=%b any=%b first=%0d/%b, ",
             "got rd=%h irq=%b any=%b first=%0d/%b"},
            n_results, want_now.read_data, want_now.group_irq, want_now.irq_any,
            want_now.first_pending, want_now.first_valid, out_item.read_data,
            out_item.group_irq, out_item.irq_any, out_item.first_pending,
            out_item.first_valid));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus: directed table under reset settings, then random phases
  // ---------------------------------------------------------------------------
  initial begin
    plan_row_t                  row;
    logic [gic_pkg::LINE_W-1:0] e_val;
    logic [gic_pkg::LINE_W-1:0] p_val;
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_item      = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    n_sent       = 0;
    n_directed   = 0;
    n_results    = 0;
    n_errors     = 0;
    n_cfg_writes = 0;
    quiet        = 1'b0;
    src_hist     = '0;
    clear_irq_state();

    // after reset: nothing pending, every line masked
    add_row(TYPED, gic_pkg::MODE_READ, gic_pkg::REG_PENDING, 2'd0, 16'h0000, '0,
            {16'h0000, 11'd0});
    add_row(TYPED, gic_pkg::MODE_READ, gic_pkg::REG_MASK, 2'd1, 16'h0000, '0,
            {16'hFFFF, 11'd0});
    // a group past the last one reads as zero
    add_row(TYPED, gic_pkg::MODE_READ, gic_pkg::REG_MASK, GROUP_NONE, 16'h0000, '0,
            {16'h0000, 11'd0});
    // no-op mode; sources outside a sample must not count as a sample
    add_row(TYPED, MODE_IDLE, gic_pkg::REG_MASK, 2'd0, 16'hFFFF, ALL_LINES,
            {16'h0000, 11'd0});
    // rising edge on every line while all are still masked
    add_row(PREDICTED, gic_pkg::MODE_SAMPLE, gic_pkg::REG_PENDING, 2'd0, 16'h0000,
            ALL_LINES, '0);
    add_row(PREDICTED, gic_pkg::MODE_READ, gic_pkg::REG_PENDING, 2'd2, 16'h0000, '0, '0);
    // unmask: all of group 0, top line of group 1, bottom line of group 2
    add_row(PREDICTED, gic_pkg::MODE_WRITE, gic_pkg::REG_MASK, 2'd0, 16'h0000, '0, '0);
    add_row(PREDICTED, gic_pkg::MODE_WRITE, gic_pkg::REG_MASK, 2'd1, 16'h7FFF, '0, '0);
    add_row(PREDICTED, gic_pkg::MODE_WRITE, gic_pkg::REG_MASK, 2'd2, 16'hFFFE, '0, '0);
    // write-one-to-clear of group 0 moves the first line up to 31
    add_row(PREDICTED, gic_pkg::MODE_WRITE, gic_pkg::REG_PENDING, 2'd0, 16'hFFFF, '0, '0);
    add_row(PREDICTED, gic_pkg::MODE_READ, gic_pkg::REG_PENDING, 2'd0, 16'h0000, '0, '0);
    // lines held high give no new edge, then fall, then the extreme lines rise
    add_row(PREDICTED, gic_pkg::MODE_SAMPLE, gic_pkg::REG_PENDING, 2'd0, 16'h0000,
            ALL_LINES, '0);
    add_row(PREDICTED, gic_pkg::MODE_SAMPLE, gic_pkg::REG_PENDING, 2'd0, 16'h0000, '0, '0);
    add_row(PREDICTED, gic_pkg::MODE_SAMPLE, gic_pkg::REG_PENDING, 2'd0, 16'h0000,
            48'h8000_0000_0001, '0);
    add_row(PREDICTED, gic_pkg::MODE_WRITE, gic_pkg::REG_MASK, 2'd2, 16'h7FFF, '0, '0);
    // accesses to the missing group are ignored
    add_row(PREDICTED, gic_pkg::MODE_WRITE, gic_pkg::REG_MASK, GROUP_NONE, 16'h0000, '0, '0);
    add_row(PREDICTED, gic_pkg::MODE_READ, gic_pkg::REG_PENDING, GROUP_NONE, 16'h0000,
            '0, '0);
    add_row(PREDICTED, gic_pkg::MODE_WRITE, gic_pkg::REG_PENDING, GROUP_NONE, 16'hFFFF,
            '0, '0);
    // clear everything until no unmasked line is left
    add_row(PREDICTED, gic_pkg::MODE_WRITE, gic_pkg::REG_PENDING, 2'd1, 16'hFFFF, '0, '0);
    add_row(PREDICTED, gic_pkg::MODE_WRITE, gic_pkg::REG_PENDING, 2'd2, 16'hFFFF,
            ALL_LINES, '0);
    add_row(PREDICTED, gic_pkg::MODE_READ, gic_pkg::REG_MASK, 2'd2, 16'h0000, '0, '0);
    add_row(PREDICTED, MODE_IDLE, gic_pkg::REG_PENDING, 2'd0, 16'h0000, ALL_LINES, '0);
    add_row(PREDICTED, gic_pkg::MODE_WRITE, gic_pkg::REG_PENDING, 2'd0, 16'hFFFF, '0, '0);
    add_row(PREDICTED, gic_pkg::MODE_READ, gic_pkg::REG_PENDING, 2'd0, 16'h0000, '0, '0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < plan_q.size(); i++) begin
      row = plan_q[i];
      send_item(row.item, row.typed, row.want);
      n_directed++;
    end
    in_valid <= 1'b0;

    // each phase reprograms both registers; pending state carries over, so a
    // polarity flip can itself look like an edge on the next sample
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      e_val = {$urandom, $urandom};
      p_val = {$urandom, $urandom};
      case (ph)
        0: begin
          e_val = '0;
          p_val = '0;
        end
        1: begin
          e_val = ALL_LINES;
          p_val = ALL_LINES;
        end
        3: begin
          e_val = '0;
          p_val = ALL_LINES;
        end
        4: p_val = '0;
        5: e_val = ALL_LINES;
        default: ;
      endcase
      cfg_set(ADDR_EDGE, e_val);
      cfg_set(ADDR_POL, p_val);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        quiet = (ph == PHASES - 1) && (k >= PHASE_ITEMS - QUIET_ITEMS);
        send_item(rand_item(), PREDICTED, '0);
      end
      in_valid <= 1'b0;
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (awaited.size() != 0)
      flag_error($sformatf("%0d results never arrived", awaited.size()));

    $display("summary: %0d items (%0d from the table), %0d results, %0d register writes",
             n_sent, n_directed, n_results, n_cfg_writes);
    $display("summary: level and edge latching under both polarities, %0d errors", n_errors);
    if (n_errors == 0) begin
      $display("grouped_interrupt_controller_unit test passed");
    end else begin
      $display("grouped_interrupt_controller_unit test failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("TIMEOUT after %0d items and %0d results", n_sent, n_results);
    $display("grouped_interrupt_controller_unit test failed");
    $finish;
  end

endmodule

@@ files.f @@
hdl/gic_pkg.sv
hdl/gic_state.sv
hdl/gic_status.sv
hdl/grouped_interrupt_controller_unit.sv
test/grouped_interrupt_controller_unit_tb.sv
